### hw/rtl/lgrs_pkg.sv
// lgrs_pkg: types, constants and cell-rule functions for the life row stencil
// used by the channel interfaces, front, queue, back and top level

package lgrs_pkg;

   localparam int ROW_WIDTH     = 64;
   localparam int SIDE_WIDTH    = 7;
   localparam int NUM_WIDTH     = 6;
   localparam int MAX_SIDE      = 64;
   localparam int MIN_SIDE      = 2;
   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;
   localparam int QUEUE_DEPTH   = 2;

   typedef logic [ROW_WIDTH-1:0]  row_type;
   typedef logic [SIDE_WIDTH-1:0] side_type;
   typedef logic [NUM_WIDTH-1:0]  num_type;

   typedef struct packed {
      row_type up;
      row_type mid;
      row_type down;
      num_type row_num;
      logic    final_row;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic side_type clamp_side(input side_type raw);
      side_type s;
      s = raw;
      if (s < side_type'(MIN_SIDE)) s = side_type'(MIN_SIDE);
      if (s > side_type'(MAX_SIDE)) s = side_type'(MAX_SIDE);
      return s;
   endfunction

   function automatic row_type side_mask(input side_type side);
      row_type m;
      if (side >= side_type'(ROW_WIDTH)) begin
         m = '1;
      end else begin
         m = (row_type'(1) << side) - row_type'(1);
      end
      return m;
   endfunction

   // b3/s23 over one row, cells off the grid are dead
   function automatic row_type next_gen(input row_type up, input row_type mid,
                                        input row_type down, input side_type side);
      row_type    m;
      row_type    u;
      row_type    c;
      row_type    d;
      row_type    ul;
      row_type    ur;
      row_type    cl;
      row_type    cr;
      row_type    dl;
      row_type    dr;
      row_type    res;
      logic [3:0] n;
      m  = side_mask(side);
      u  = up & m;
      c  = mid & m;
      d  = down & m;
      ul = u << 1;
      ur = u >> 1;
      cl = c << 1;
      cr = c >> 1;
      dl = d << 1;
      dr = d >> 1;
      res = '0;
      for (int j = 0; j < ROW_WIDTH; j++) begin
         n = {3'b000, ul[j]} + {3'b000, u[j]} + {3'b000, ur[j]}
           + {3'b000, cl[j]} + {3'b000, cr[j]}
           + {3'b000, dl[j]} + {3'b000, d[j]} + {3'b000, dr[j]};
         res[j] = (n == 4'(BIRTH_COUNT)) || ((n == 4'(SURVIVE_COUNT)) && c[j]);
      end
      return res & m;
   endfunction

endpackage

### hw/rtl/lgrs_ifs.sv
// lgrs_req_if and lgrs_rsp_if: valid/ready channels for row words in and out
// depends on lgrs_pkg

interface lgrs_req_if;
   logic               valid;
   logic               ready;
   lgrs_pkg::row_type  row_bits;
   modport source (output valid, output row_bits, input ready);
   modport sink   (input valid, input row_bits, output ready);
endinterface

interface lgrs_rsp_if;
   logic               valid;
   logic               ready;
   lgrs_pkg::row_type  next_row_bits;
   lgrs_pkg::num_type  row_number;
   logic               last_row;
   modport source (output valid, output next_row_bits, output row_number,
                   output last_row, input ready);
   modport sink   (input valid, input next_row_bits, input row_number,
                   input last_row, output ready);
endinterface

### hw/rtl/lgrs_front.sv
// lgrs_front: takes row words, keeps the two previous rows and the row count,
// pushes one stencil job per row after the first; depends on lgrs_pkg, lgrs_ifs

module lgrs_front (
   input  logic               clock,
   input  logic               reset,
   lgrs_req_if.sink           req,
   input  lgrs_pkg::side_type side,
   input  logic               queue_full,
   output lgrs_pkg::slot_type push
);

   lgrs_pkg::row_type  above_ff, above_in;
   lgrs_pkg::row_type  middle_ff, middle_in;
   lgrs_pkg::side_type rows_ff, rows_in;
   lgrs_pkg::row_type  row_in;
   logic [lgrs_pkg::SIDE_WIDTH:0] rows_next;
   logic               accept;
   logic               grid_end;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign row_in    = req.row_bits & lgrs_pkg::side_mask(side);
   assign rows_next = {1'b0, rows_ff} + 8'd1;
   assign grid_end  = rows_next >= {1'b0, side};

   always_comb begin
      above_in                = above_ff;
      middle_in               = middle_ff;
      rows_in                 = rows_ff;
      push.valid              = 1'b0;
      push.entry.up           = above_ff;
      push.entry.mid          = middle_ff;
      push.entry.down         = row_in;
      push.entry.row_num      = lgrs_pkg::num_type'(rows_ff - 7'd1);
      push.entry.final_row    = grid_end;
      if (accept) begin
         if (rows_ff == '0) begin
            above_in  = '0;
            middle_in = row_in;
            rows_in   = 7'd1;
         end else begin
            push.valid = 1'b1;
            if (grid_end) begin
               above_in  = '0;
               middle_in = '0;
               rows_in   = '0;
            end else begin
               above_in  = middle_ff;
               middle_in = row_in;
               rows_in   = rows_next[lgrs_pkg::SIDE_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
      above_ff  <= above_in;
      middle_ff <= middle_in;
   end

endmodule

### hw/rtl/lgrs_queue.sv
// lgrs_queue: short job queue between front and back
// depends on lgrs_pkg

module lgrs_queue (
   input  logic               clock,
   input  logic               reset,
   input  lgrs_pkg::slot_type push,
   input  logic               pop,
   output lgrs_pkg::slot_type head,
   output logic               full
);

   localparam int PTR_WIDTH   = $clog2(lgrs_pkg::QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(lgrs_pkg::QUEUE_DEPTH + 1);

   lgrs_pkg::entry_type    slots_ff [lgrs_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = count_ff == COUNT_WIDTH'(lgrs_pkg::QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = slots_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + COUNT_WIDTH'(1);
      if (do_pop && !do_push) count_in = count_ff - COUNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) slots_ff[wr_ptr_ff] <= push.entry;
   end

endmodule

### hw/rtl/lgrs_back.sv
// lgrs_back: evaluates the cell rule on queued jobs into the result register,
// two result words for a grid's last row; depends on lgrs_pkg, lgrs_ifs

module lgrs_back (
   input  logic               clock,
   input  logic               reset,
   input  lgrs_pkg::side_type side,
   input  lgrs_pkg::slot_type head,
   output logic               pop,
   lgrs_rsp_if.source         rsp
);

   logic              valid_ff, valid_in;
   logic              phase_ff, phase_in;
   lgrs_pkg::row_type bits_ff, bits_in;
   lgrs_pkg::num_type num_ff, num_in;
   logic              last_ff, last_in;
   logic              load;

   assign load = head.valid && (!valid_ff || rsp.ready);

   always_comb begin
      pop      = 1'b0;
      phase_in = phase_ff;
      bits_in  = bits_ff;
      num_in   = num_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp.ready;
      if (load) begin
         valid_in = 1'b1;
         if (!phase_ff) begin
            bits_in = lgrs_pkg::next_gen(head.entry.up, head.entry.mid,
                                         head.entry.down, side);
            num_in  = head.entry.row_num;
            last_in = 1'b0;
            if (head.entry.final_row) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            // successor of the grid's last row, nothing below it
            bits_in  = lgrs_pkg::next_gen(head.entry.mid, head.entry.down, '0, side);
            num_in   = lgrs_pkg::num_type'(side - 7'd1);
            last_in  = 1'b1;
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      bits_ff <= bits_in;
      num_ff  <= num_in;
      last_ff <= last_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.next_row_bits = bits_ff;
   assign rsp.row_number    = num_ff;
   assign rsp.last_row      = last_ff;

endmodule

### hw/rtl/life_generation_row_stencil.sv
// life_generation_row_stencil: top level of the b3/s23 row stencil
// depends on lgrs_pkg, lgrs_ifs, lgrs_front, lgrs_queue, lgrs_back

// One generation of the game of life on a square grid of side csr_write_data
// (clamped to 2..64, reset 64), cells off the grid dead. Rows stream in on
// req_word one word per cycle while the job queue is not full, top row first;
// all 64 cells of a row are evaluated in parallel. The first row of a grid
// gives no result, each later row gives the successor of the row above it,
// and the grid's last row gives a second word, its own successor, with
// last_row set. A taken row's job passes through the job queue and then the
// result register, which loads when the output is free. The back end sustains
// one result word per cycle while the output is ready, and a grid of N rows
// gives N words, so grids follow one another at one row per cycle with no gap.
// A two-entry job queue lets the front keep taking rows while the result side
// is stalled or emitting the extra last word.

module life_generation_row_stencil (
   input  logic                clock,
   input  logic                reset,
   lgrs_req_if.sink            req_word,
   lgrs_rsp_if.source          rsp_word,
   input  logic                csr_write_enable,
   input  lgrs_pkg::side_type  csr_write_data
);

   lgrs_pkg::side_type grid_side_ff, grid_side_in;
   lgrs_pkg::side_type side;
   lgrs_pkg::slot_type push;
   lgrs_pkg::slot_type head;
   logic               queue_full;
   logic               pop;

   assign grid_side_in = csr_write_enable ? csr_write_data : grid_side_ff;
   assign side         = lgrs_pkg::clamp_side(grid_side_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= lgrs_pkg::side_type'(lgrs_pkg::MAX_SIDE);
      end else begin
         grid_side_ff <= grid_side_in;
      end
   end

   lgrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_word),
      .side       (side),
      .queue_full (queue_full),
      .push       (push)
   );

   lgrs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   lgrs_back u_back (
      .clock (clock),
      .reset (reset),
      .side  (side),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_word)
   );

   // no job is offered to a full queue
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !queue_full)
      else $error("job pushed into full queue");

   // the last word of a grid carries the bottom row index
   assert property (@(posedge clock) disable iff (reset)
      rsp_word.valid && rsp_word.last_row |->
         rsp_word.row_number == lgrs_pkg::num_type'(side - 7'd1))
      else $error("last word has wrong row number");

   // cells beyond the side are dead
   assert property (@(posedge clock) disable iff (reset)
      rsp_word.valid |->
         (rsp_word.next_row_bits & ~lgrs_pkg::side_mask(side)) == '0)
      else $error("live cell beyond grid side");

   // a popped job always had a result slot to go to
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid ##1 rsp_word.valid)
      else $error("job popped without a result word");

endmodule

### sim/life_generation_row_stencil_tb.sv
// life_generation_row_stencil_tb: self-checking bench for the b3/s23 row stencil,
// predicting every result word from its own copy of the grid rows and side
// depends on lgrs_pkg, lgrs_ifs and life_generation_row_stencil

module life_generation_row_stencil_tb;

   localparam int RANDOM_ROWS   = 1420;
   localparam int MAX_GAP       = 19;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam int TIMEOUT       = 8_000_000;

   typedef struct {
      lgrs_pkg::row_type bits;
      lgrs_pkg::num_type num;
      logic              last;
   } row_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   lgrs_pkg::side_type csr_write_data;
   logic               sink_ready;
   logic               hold_active;

   lgrs_req_if req_if ();
   lgrs_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready & ~hold_active;

   life_generation_row_stencil dut (
      .clock            (clock),
      .reset            (reset),
      .req_word         (req_if),
      .rsp_word         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predicted state of the stencil
   lgrs_pkg::side_type side_cfg   = lgrs_pkg::side_type'(lgrs_pkg::MAX_SIDE);
   lgrs_pkg::row_type  row_prev   = '0;
   lgrs_pkg::row_type  row_last   = '0;
   int                 rows_taken = 0;
   row_result_type     successor_rows[$];

   int mismatch_count = 0;
   int rows_sent      = 0;
   int hold_request   = 0;
   bit req_gaps_on    = 1'b1;
   bit rsp_gaps_on    = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int grid_cells(input lgrs_pkg::side_type raw);
      if (raw < lgrs_pkg::side_type'(lgrs_pkg::MIN_SIDE)) return lgrs_pkg::MIN_SIDE;
      if (raw > lgrs_pkg::side_type'(lgrs_pkg::MAX_SIDE)) return lgrs_pkg::MAX_SIDE;
      return int'(raw);
   endfunction

   function automatic lgrs_pkg::row_type grid_keep(input int side);
      lgrs_pkg::row_type keep;
      keep = '0;
      for (int j = 0; j < side; j++) keep[j] = 1'b1;
      return keep;
   endfunction

   function automatic lgrs_pkg::row_type life_row(input lgrs_pkg::row_type above,
                                                  input lgrs_pkg::row_type centre,
                                                  input lgrs_pkg::row_type below,
                                                  input int side);
      lgrs_pkg::row_type keep;
      lgrs_pkg::row_type a;
      lgrs_pkg::row_type c;
      lgrs_pkg::row_type b;
      lgrs_pkg::row_type result;
      int                alive_n;
      int                col;
      keep   = grid_keep(side);
      a      = above & keep;
      c      = centre & keep;
      b      = below & keep;
      result = '0;
      for (int j = 0; j < side; j++) begin
         alive_n = 0;
         for (int dj = -1; dj <= 1; dj++) begin
            col = j + dj;
            if (col >= 0 && col < side) begin
               alive_n += int'(a[col]) + int'(b[col]);
               if (dj != 0) alive_n += int'(c[col]);
            end
         end
         result[j] = (alive_n == lgrs_pkg::BIRTH_COUNT) ||
                     (alive_n == lgrs_pkg::SURVIVE_COUNT && c[j]);
      end
      return result;
   endfunction

   task automatic take_grid_row(input lgrs_pkg::row_type raw);
      int                side;
      lgrs_pkg::row_type r;
      row_result_type    res;
      side = grid_cells(side_cfg);
      r    = raw & grid_keep(side);
      if (rows_taken == 0) begin
         row_prev   = '0;
         row_last   = r;
         rows_taken = 1;
         return;
      end
      res.bits = life_row(row_prev, row_last, r, side);
      res.num  = lgrs_pkg::num_type'(rows_taken - 1);
      res.last = 1'b0;
      successor_rows = {successor_rows, res};
      row_prev   = row_last;
      row_last   = r;
      rows_taken = (rows_taken + 1) & 'h7f;
      if (rows_taken >= side) begin
         res.bits = life_row(row_prev, row_last, '0, side);
         res.num  = lgrs_pkg::num_type'(side - 1);
         res.last = 1'b1;
         successor_rows = {successor_rows, res};
         row_prev   = '0;
         row_last   = '0;
         rows_taken = 0;
      end
   endtask

   function automatic lgrs_pkg::row_type random_row();
      lgrs_pkg::row_type a;
      lgrs_pkg::row_type b;
      lgrs_pkg::row_type c;
      a = {$urandom(), $urandom()};
      b = {$urandom(), $urandom()};
      c = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
         0: return a & b;
         1: return a;
         2: return a | b;
         default: return a & b & c;
      endcase
   endfunction

   task automatic send_row_word(input lgrs_pkg::row_type word);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.row_bits <= word;
      do @(posedge clock); while (!req_if.ready);
      take_grid_row(word);
      rows_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (successor_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_side(input lgrs_pkg::side_type value);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      side_cfg = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_reset_side();
      for (int i = 0; i < lgrs_pkg::MAX_SIDE; i++) send_row_word(random_row());
      drain_results();
   endtask

   task automatic test_directed_edges();
      // sides below the minimum act as two
      write_grid_side(lgrs_pkg::side_type'(0));
      send_row_word('1);
      send_row_word('1);
      write_grid_side(lgrs_pkg::side_type'(1));
      send_row_word(64'hFFFF_FFFF_FFFF_FFFE);
      send_row_word(64'h1);
      // live cells beyond the grid edge
      write_grid_side(lgrs_pkg::side_type'(3));
      send_row_word(64'hFFFF_FFFF_FFFF_FFF8);
      send_row_word('1);
      send_row_word(64'h5);
      // blinker
      write_grid_side(lgrs_pkg::side_type'(4));
      send_row_word(64'h2);
      send_row_word(64'h2);
      send_row_word(64'h2);
      send_row_word('0);
      drain_results();
   endtask

   task automatic test_side_change_mid_grid();
      write_grid_side(lgrs_pkg::side_type'(8));
      for (int i = 0; i < 5; i++) send_row_word(random_row());
      write_grid_side(lgrs_pkg::side_type'(4));
      send_row_word(random_row());
      for (int i = 0; i < 2; i++) send_row_word(random_row());
      write_grid_side(lgrs_pkg::side_type'(6));
      for (int i = 0; i < 4; i++) send_row_word(random_row());
      drain_results();
   endtask

   task automatic test_backpressure();
      write_grid_side(lgrs_pkg::side_type'(16));
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 48; i++) send_row_word(random_row());
      drain_results();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_random_grids();
      int                 first;
      int                 pick;
      int                 grids;
      int                 n;
      lgrs_pkg::side_type side;
      first = rows_sent;
      while (rows_sent - first < RANDOM_ROWS) begin
         pick = $urandom_range(0, 3);
         req_gaps_on = pick[0];
         rsp_gaps_on = pick[1];
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            side = lgrs_pkg::side_type'($urandom_range(0, 127));
         end else if (pick == 1) begin
            side = lgrs_pkg::side_type'(lgrs_pkg::MAX_SIDE);
         end else begin
            side = lgrs_pkg::side_type'($urandom_range(2, 12));
         end
         write_grid_side(side);
         grids = $urandom_range(1, 3);
         for (int g = 0; g < grids; g++) begin
            n = grid_cells(side_cfg);
            // a cut-short grid carries its state into the rows sent after it
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
            for (int i = 0; i < n; i++) send_row_word(random_row());
         end
      end
      drain_results();
   endtask

   initial begin : hold_counter
      int hold_left;
      hold_left   = 0;
      hold_active = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_active <= 1'b1;
            hold_left--;
         end else begin
            hold_active <= 1'b0;
         end
      end
   end

   initial begin : result_sink
      int             stall;
      row_result_type want;
      sink_ready = 1'b0;
      forever begin
         stall = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         @(negedge clock);
         if (stall > 0) begin
            sink_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         sink_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         if (successor_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected word: row %0d bits %h last %0b",
                        rsp_if.row_number, rsp_if.next_row_bits, rsp_if.last_row);
         end else begin
            want = successor_rows.pop_front();
            if (rsp_if.next_row_bits !== want.bits || rsp_if.row_number !== want.num ||
                rsp_if.last_row !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"word mismatch: expected row %0d bits %h last %0b,",
                            " got row %0d bits %h last %0b"},
                           want.num, want.bits, want.last, rsp_if.row_number,
                           rsp_if.next_row_bits, rsp_if.last_row);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT);
      $display("life_generation_row_stencil_tb: done, errors");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.row_bits  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_side();
      test_directed_edges();
      test_side_change_mid_grid();
      test_backpressure();
      test_random_grids();
      if (mismatch_count == 0) begin
         $display("life_generation_row_stencil_tb: done, clean");
      end else begin
         $display("life_generation_row_stencil_tb: done, errors");
      end
      $finish;
   end

endmodule
